// ===== rtl/s1dp_pkg.sv =====
// shared types, constants and helpers of the steim-1 difference packer
package s1dp_pkg;

	localparam int SAMPLE_W = 32;
	localparam int OFFSET_W = 10;
	localparam int COUNT_W = 12;
	localparam int FRAME_W = 6;
	localparam int WPOS_W = 4;
	localparam int OUT_TDATA_W = 56;

	localparam int MAX_FRAMES = 63;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam logic [FRAME_W-1:0] FRAMES_RESET = 6'd7;

	localparam logic [WPOS_W-1:0] WPOS_RESET = 4'd2;
	localparam logic [WPOS_W-1:0] WPOS_LAST = 4'd14;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	localparam logic [1:0] CODE_8 = 2'd1;
	localparam logic [1:0] CODE_16 = 2'd2;
	localparam logic [1:0] CODE_32 = 2'd3;

	localparam logic [OFFSET_W-1:0] OFS_FIRST = 10'd1;
	localparam logic [OFFSET_W-1:0] OFS_LAST = 10'd2;

	typedef enum logic [1:0] {
		WC_8,
		WC_16,
		WC_32
	} wclass_t;

	typedef struct packed {
		logic                cmd;
		logic [SAMPLE_W-1:0] sample;
		logic [SAMPLE_W-1:0] diff;
		wclass_t             wclass;
	} qentry_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [SAMPLE_W-1:0] value;
		logic                done;
		logic [COUNT_W-1:0]  count;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_OPEN,
		ST_NIB,
		ST_DATA,
		ST_CLOSE,
		ST_END
	} bstate_t;

	// narrowest packing that holds a difference
	function automatic wclass_t classify(input logic [SAMPLE_W-1:0] d);
		wclass_t c;
		if ((d[31:7] == '0) || (d[31:7] == '1)) begin
			c = WC_8;
		end else if ((d[31:15] == '0) || (d[31:15] == '1)) begin
			c = WC_16;
		end else begin
			c = WC_32;
		end
		return c;
	endfunction

endpackage

// ===== rtl/s1dp_queue.sv =====
// small flip-flop queue between the front and the packer
module s1dp_queue
	import s1dp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  qentry_t push_entry,
	output logic    full,
	input  logic    pop,
	output qentry_t pop_entry,
	output logic    nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	qentry_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full = (fill_q == CNT_FULL);
	assign nonempty = (fill_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && nonempty;
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

// ===== rtl/s1dp_front.sv =====
// input side: takes words, forms first differences and classifies their width
module s1dp_front
	import s1dp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,
	input  logic                s_tuser,
	input  logic                q_full,
	output logic                q_push,
	output qentry_t             q_entry
);

	logic [SAMPLE_W-1:0] prev_q;
	logic [SAMPLE_W-1:0] diff;

	assign s_tready = !q_full;
	assign q_push = s_tvalid && s_tready;
	assign diff = s_tdata - prev_q;

	always_comb begin
		q_entry.cmd = s_tuser;
		q_entry.sample = s_tdata;
		q_entry.diff = diff;
		q_entry.wclass = classify(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (q_push && (s_tuser == CMD_SAMPLE)) begin
			prev_q <= s_tdata;
		end
	end

endmodule

// ===== rtl/s1dp_back.sv =====
// packer: difference buffer, frame bookkeeping and word writes
module s1dp_back
	import s1dp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  qentry_t                q_entry,
	output logic                   q_pop,
	input  logic [FRAME_W-1:0]     frames_cfg,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	bstate_t state_q, state_d;

	logic [SAMPLE_W-1:0] diff_q [4];
	logic [SAMPLE_W-1:0] smp_q [4];
	wclass_t             cls_q [4];
	logic [2:0]          cnt_q;
	logic [SAMPLE_W-1:0] tail_q;
	logic [SAMPLE_W-1:0] nib_q;
	logic [WPOS_W-1:0]   wpos_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [COUNT_W-1:0]  packed_q;
	logic                open_q;
	logic                flush_q;
	logic [SAMPLE_W-1:0] w_q;

	result_t pend_q;
	logic    pend_v_q;
	result_t out_q;
	logic    out_last_q;
	logic    out_v_q;

	logic                all8_2, all8_3, all8_4, all16_2;
	logic                loop_cond, go_pack;
	logic [2:0]          k;
	logic [1:0]          code;
	logic [SAMPLE_W-1:0] word;
	logic [WPOS_W-1:0]   wp, wp_next;
	logic [4:0]          shamt;
	logic [SAMPLE_W-1:0] nib_new;
	logic [FRAME_W-1:0]  frame_next;
	logic [FRAME_W-1:0]  eff;
	logic                close_due;
	logic                out_free, emit_ok, emit, emit_go, fin;
	result_t             res;

	assign all8_2 = (cls_q[0] == WC_8) && (cls_q[1] == WC_8);
	assign all8_3 = all8_2 && (cls_q[2] == WC_8);
	assign all8_4 = all8_3 && (cls_q[3] == WC_8);
	assign all16_2 = (cls_q[0] != WC_32) && (cls_q[1] != WC_32);

	always_comb begin
		unique case (cnt_q)
			3'd1: loop_cond = (cls_q[0] == WC_32);
			3'd2: loop_cond = !all8_2;
			3'd3: loop_cond = !all8_3;
			3'd4: loop_cond = 1'b1;
			default: loop_cond = 1'b0;
		endcase
	end

	assign go_pack = flush_q ? (cnt_q != 3'd0) : loop_cond;

	always_comb begin
		priority if ((cnt_q == 3'd4) && all8_4) begin
			k = 3'd4;
			code = CODE_8;
			word = {diff_q[0][7:0], diff_q[1][7:0], diff_q[2][7:0], diff_q[3][7:0]};
		end else if ((cnt_q >= 3'd2) && all16_2) begin
			k = 3'd2;
			code = CODE_16;
			word = {diff_q[0][15:0], diff_q[1][15:0]};
		end else begin
			k = 3'd1;
			code = CODE_32;
			word = diff_q[0];
		end
	end

	// slot in the frame, held below the last data word
	assign wp = (wpos_q > WPOS_LAST) ? WPOS_LAST : wpos_q;
	assign wp_next = wp + 4'd1;
	assign shamt = 5'd28 - {wp, 1'b0};
	assign nib_new = nib_q | ({30'd0, code} << shamt);
	assign frame_next = (wp == WPOS_LAST) ? frame_q + 6'd1 : frame_q;

	always_comb begin
		if (frames_cfg == '0) begin
			eff = 6'd1;
		end else if (int'(frames_cfg) > MAX_FRAMES) begin
			eff = FRAME_W'(MAX_FRAMES);
		end else begin
			eff = frames_cfg;
		end
	end

	assign close_due = (frame_next >= eff);

	// one result is held back so the final one of an input can be tagged
	assign out_free = !out_v_q || m_tready;
	assign emit_ok = !pend_v_q || out_free;
	assign emit_go = emit && emit_ok;

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		emit = 1'b0;
		fin = 1'b0;
		res.offset = OFS_FIRST;
		res.value = smp_q[0];
		res.done = 1'b0;
		res.count = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (go_pack) begin
					state_d = open_q ? ST_NIB : ST_OPEN;
				end else if (flush_q && open_q) begin
					state_d = ST_CLOSE;
				end else begin
					state_d = ST_END;
				end
			end
			ST_OPEN: begin
				emit = 1'b1;
				if (emit_ok) state_d = ST_NIB;
			end
			ST_NIB: begin
				emit = 1'b1;
				res.offset = {frame_q, 4'd0};
				res.value = nib_new;
				res.count = packed_q + COUNT_W'(k);
				if (emit_ok) state_d = ST_DATA;
			end
			ST_DATA: begin
				emit = 1'b1;
				res.offset = {frame_q, wp_next};
				res.value = w_q;
				res.count = packed_q;
				if (emit_ok) state_d = close_due ? ST_CLOSE : ST_EVAL;
			end
			ST_CLOSE: begin
				emit = 1'b1;
				res.offset = OFS_LAST;
				res.value = tail_q;
				res.done = 1'b1;
				res.count = packed_q;
				if (emit_ok) state_d = ST_EVAL;
			end
			ST_END: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// buffer and output payload
	always_ff @(posedge clk) begin
		if (q_pop && (q_entry.cmd == CMD_SAMPLE) && (cnt_q < 3'd4)) begin
			diff_q[cnt_q[1:0]] <= q_entry.diff;
			smp_q[cnt_q[1:0]] <= q_entry.sample;
			cls_q[cnt_q[1:0]] <= q_entry.wclass;
		end else if ((state_q == ST_NIB) && emit_go) begin
			if (k == 3'd2) begin
				diff_q[0] <= diff_q[2];
				diff_q[1] <= diff_q[3];
				smp_q[0] <= smp_q[2];
				smp_q[1] <= smp_q[3];
				cls_q[0] <= cls_q[2];
				cls_q[1] <= cls_q[3];
			end else if (k == 3'd1) begin
				for (int i = 0; i < 3; i++) begin
					diff_q[i] <= diff_q[i+1];
					smp_q[i] <= smp_q[i+1];
					cls_q[i] <= cls_q[i+1];
				end
			end
		end
		if ((state_q == ST_NIB) && emit_go) begin
			w_q <= word;
		end
		if (emit_go) begin
			pend_q <= res;
			if (pend_v_q) begin
				out_q <= pend_q;
				out_last_q <= 1'b0;
			end
		end else if (fin) begin
			out_q <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			tail_q <= '0;
			nib_q <= '0;
			wpos_q <= WPOS_RESET;
			frame_q <= '0;
			packed_q <= '0;
			open_q <= 1'b0;
			flush_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				flush_q <= (q_entry.cmd == CMD_FLUSH);
				if ((q_entry.cmd == CMD_SAMPLE) && (cnt_q < 3'd4)) begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
			if (emit_go) begin
				unique case (state_q)
					ST_OPEN: begin
						open_q <= 1'b1;
						packed_q <= '0;
						frame_q <= '0;
						nib_q <= '0;
						wpos_q <= WPOS_RESET;
					end
					ST_NIB: begin
						nib_q <= nib_new;
						packed_q <= packed_q + COUNT_W'(k);
						cnt_q <= (cnt_q > k) ? cnt_q - k : 3'd0;
						tail_q <= smp_q[k[1:0] - 2'd1];
					end
					ST_DATA: begin
						if (wp == WPOS_LAST) begin
							wpos_q <= '0;
							nib_q <= '0;
							frame_q <= frame_next;
						end else begin
							wpos_q <= wp_next;
						end
					end
					ST_CLOSE: open_q <= 1'b0;
					default: ;
				endcase
			end
			if ((emit_go && pend_v_q) || fin) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			if (emit_go) begin
				pend_v_q <= 1'b1;
			end else if (fin) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {2'b00, out_q.count, out_q.value, out_q.offset};
	assign m_tuser = out_q.done;
	assign m_tlast = out_last_q;

endmodule

// ===== rtl/steim1_difference_packer.sv =====
// top level of the steim-1 difference packer
//
// s_* channel: one word per sample or command. s_tuser is the command
// (0 = new sample, 1 = flush and close the record), s_tdata the signed sample.
// m_* channel: one word per write into the record image. m_tlast marks the
// final write caused by an input word, m_tuser the write that closes a record.
// cfg_* channel: frames per record, always ready, to be written while idle.
//
// the front takes an input word every cycle while its queue has room; the
// packer then works one queued word at a time. a sample that packs nothing
// passes the idle, evaluation and end states; each packed data word adds a
// nibble word write, a data word write and a fresh look at the buffer, a
// record open adds an open write and a close a closing write. each write
// waits one write in a holding stage so the last can be tagged.
// reset clears previous sample, buffer fill, record state and queue; no
// clearing pass is needed. when m_tready is low the output word holds, the
// packer stops at its next write and the queue fills, then s_tready drops.
module steim1_difference_packer
	import s1dp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [SAMPLE_W-1:0]    s_tdata,   // [31:0] sample
	input  logic                   s_tuser,   // [0] command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [9:0] word_offset, [41:10] word_value,
	                                          // [53:42] samples_in_record, [55:54] zero
	output logic                   m_tuser,   // [0] record_done
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [FRAME_W-1:0]     cfg_data
);

	logic               q_push;
	qentry_t            q_in;
	logic               q_full;
	logic               q_pop;
	qentry_t            q_out;
	logic               q_nonempty;
	logic [FRAME_W-1:0] frames_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frames_q <= cfg_data;
		end
	end

	s1dp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_in)
	);

	s1dp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (q_out),
		.nonempty   (q_nonempty)
	);

	s1dp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_nonempty),
		.q_entry    (q_out),
		.q_pop      (q_pop),
		.frames_cfg (frames_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== rtl/s1dp_checker.sv =====
// port-level checks of the steim-1 difference packer and their binding
module s1dp_checker
	import s1dp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	// the closing write is always the last-sample slot
	a_done_ofs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[9:0] == OFS_LAST)
		else $error("record close not at last-sample slot");

	// first-sample write opens a record with nothing packed
	a_first_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[9:0] == OFS_FIRST) |-> m_tdata[53:42] == '0)
		else $error("first-sample write with packed count");

	// a nibble word is written only after a code was added
	a_nib_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[3:0] == 4'd0) |-> m_tdata[41:10] != '0)
		else $error("empty nibble word written");

endmodule

bind steim1_difference_packer s1dp_checker u_s1dp_checker (.*);
